// ===== rtl/sptri_pkg.sv =====
// Shared widths, register codes, reset values and helper types for the stereo triangulator.
package sptri_pkg;

   localparam int PIX_W      = 16;
   localparam int COORD_W    = 32;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // Baseline magnitude, depth quotient (20 fraction bits) and depth per pixel
   localparam int BMAG_W     = 32;
   localparam int Q_SHIFT    = 20;
   localparam int Q_W        = BMAG_W + Q_SHIFT;
   localparam int P_SHIFT    = 4;
   localparam int P_W        = Q_W + P_SHIFT;
   localparam int Z_DROP     = 16;
   localparam int ZMAG_W     = Q_W - Z_DROP;
   localparam int P_LO_W     = 32;
   localparam int P_HI_W     = P_W - P_LO_W;
   localparam int PHI_PROD_W = P_HI_W + PIX_W;
   localparam int PLO_PROD_W = P_LO_W + PIX_W;
   localparam int XY_SHIFT   = 20;
   localparam int HI_SHIFT   = P_LO_W - XY_SHIFT;
   localparam int MAG_W      = PHI_PROD_W + HI_SHIFT;

   localparam logic [PIX_W-1:0]   FOCAL_RESET    = 16'd8000;
   localparam logic [PIX_W-1:0]   PRIN_U_RESET   = 16'd5120;
   localparam logic [PIX_W-1:0]   PRIN_V_RESET   = 16'd3840;
   localparam logic [COORD_W-1:0] BASELINE_RESET = 32'hFF38_0000;
   localparam logic [PIX_W-1:0]   MIN_DISP_RESET = 16'd16;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_FOCAL_LENGTH  = 3'd0,
      CSR_PRINCIPAL_U   = 3'd1,
      CSR_PRINCIPAL_V   = 3'd2,
      CSR_BASELINE_TERM = 3'd3,
      CSR_MIN_DISPARITY = 3'd4
   } csr_index_type;

   // Sideband carried alongside the depth division
   typedef struct packed {
      logic             rej;
      logic             dneg;
      logic             offx_neg;
      logic [PIX_W-1:0] offx_mag;
      logic             offy_neg;
      logic [PIX_W-1:0] offy_mag;
   } side1_type;

   // Sideband carried alongside the focal division
   typedef struct packed {
      side1_type         s1;
      logic [ZMAG_W-1:0] zmag;
   } side2_type;

   localparam int SIDE1_W = $bits(side1_type);
   localparam int SIDE2_W = $bits(side2_type);

   typedef struct packed {
      logic               sat;
      logic [COORD_W-1:0] value;
   } clamp_type;

   // Clamp a sign-magnitude value into signed Q16.16
   function automatic clamp_type clamp_q16(input logic [MAG_W-1:0] mag, input logic neg);
      clamp_type        r;
      logic [MAG_W-1:0] lim;
      lim = neg ? MAG_W'(33'h0_8000_0000) : MAG_W'(33'h0_7FFF_FFFF);
      r.sat = mag > lim;
      r.value = r.sat ? lim[COORD_W-1:0] : mag[COORD_W-1:0];
      if (neg) begin
         r.value = COORD_W'(0) - r.value;
      end
      return r;
   endfunction

endpackage

// ===== rtl/sptri_req_if.sv =====
// Input channel: one matched stereo pair per transfer.
interface sptri_req_if;
   import sptri_pkg::*;
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] left_u;
   logic [PIX_W-1:0] left_v;
   logic [PIX_W-1:0] right_u;
   modport source(output valid, output left_u, output left_v, output right_u, input ready);
   modport sink(input valid, input left_u, input left_v, input right_u, output ready);
endinterface

// ===== rtl/sptri_rsp_if.sv =====
// Result channel: one camera-frame point per transfer.
interface sptri_rsp_if;
   import sptri_pkg::*;
   logic                      valid;
   logic                      ready;
   logic                      valid_res;
   logic                      saturated;
   logic signed [COORD_W-1:0] cam_x;
   logic signed [COORD_W-1:0] cam_y;
   logic signed [COORD_W-1:0] cam_z;
   modport source(output valid, output valid_res, output saturated, output cam_x,
                  output cam_y, output cam_z, input ready);
   modport sink(input valid, input valid_res, input saturated, input cam_x,
                input cam_y, input cam_z, output ready);
endinterface

// ===== rtl/sptri_csr_if.sv =====
// Configuration write channel: register index and data.
interface sptri_csr_if;
   import sptri_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_ADDR_W-1:0] addr;
   logic [CSR_DATA_W-1:0] data;
   modport source(output valid, output addr, output data, input ready);
   modport sink(input valid, input addr, input data, output ready);
endinterface

// ===== rtl/stereo_point_triangulator_unit.sv =====
// Rectified stereo triangulation: one matched pair in, one camera-frame point out.
// Accepts one pair per cycle while ready is high; each result passes in order through:
// an input stage, a 52-cell depth divider and a 56-cell focal divider (one quotient bit
// per cell), a multiply stage, a clamp stage and the output register. The pipeline
// freezes only when its last stage holds a result while the output register is still
// full and not taken; ready then drops until the result channel moves. Configuration
// writes are taken in every cycle and must only be issued while the pipeline is empty.
module stereo_point_triangulator_unit (
   input  logic               clock,
   input  logic               reset,
   sptri_req_if.sink          req_ch,
   sptri_rsp_if.source        rsp_ch,
   sptri_csr_if.sink          csr_ch
);
   import sptri_pkg::*;

   // Configuration registers
   logic [PIX_W-1:0]   focal_ff, prin_u_ff, prin_v_ff, min_disp_ff;
   logic [COORD_W-1:0] baseline_ff;

   logic adv;

   // Input stage
   logic               s0_valid_ff;
   side1_type          s0_side_ff, s0_side_in;
   logic [BMAG_W-1:0]  s0_bmag_ff, s0_bmag_in;
   logic [PIX_W-1:0]   s0_disp_ff, s0_disp_in;

   // Divider outputs
   logic               d1_valid;
   logic [Q_W-1:0]     d1_quot;
   logic [SIDE1_W-1:0] d1_side;
   logic [SIDE2_W-1:0] d2_side_in;
   logic [PIX_W-1:0]   focal_eff;
   logic               d2_valid;
   logic [P_W-1:0]     d2_quot;
   logic [SIDE2_W-1:0] d2_side;
   side2_type          d2_side_s;

   // Multiply stage
   logic                  m1_valid_ff;
   side2_type             m1_side_ff;
   logic [PHI_PROD_W-1:0] m1_phx_ff, m1_phy_ff, m1_phx_in, m1_phy_in;
   logic [PLO_PROD_W-1:0] m1_plx_ff, m1_ply_ff, m1_plx_in, m1_ply_in;

   // Clamp stage
   logic               m2_valid_ff;
   logic               m2_res_ff, m2_res_in;
   logic               m2_sat_ff, m2_sat_in;
   logic [COORD_W-1:0] m2_x_ff, m2_y_ff, m2_z_ff, m2_x_in, m2_y_in, m2_z_in;
   logic [MAG_W-1:0]   xm, ym;
   clamp_type          cx, cy, cz;

   // Output register
   logic               out_valid_ff, out_valid_in;
   logic               out_res_ff, out_sat_ff;
   logic [COORD_W-1:0] out_x_ff, out_y_ff, out_z_ff;

   // Hold everything only when the last stage cannot move into the output register
   assign adv = !(m2_valid_ff && out_valid_ff && !rsp_ch.ready);
   assign req_ch.ready = adv;
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         focal_ff    <= FOCAL_RESET;
         prin_u_ff   <= PRIN_U_RESET;
         prin_v_ff   <= PRIN_V_RESET;
         baseline_ff <= BASELINE_RESET;
         min_disp_ff <= MIN_DISP_RESET;
      end else if (csr_ch.valid) begin
         case (csr_index_type'(csr_ch.addr))
            CSR_FOCAL_LENGTH:  focal_ff    <= csr_ch.data[PIX_W-1:0];
            CSR_PRINCIPAL_U:   prin_u_ff   <= csr_ch.data[PIX_W-1:0];
            CSR_PRINCIPAL_V:   prin_v_ff   <= csr_ch.data[PIX_W-1:0];
            CSR_BASELINE_TERM: baseline_ff <= csr_ch.data[COORD_W-1:0];
            CSR_MIN_DISPARITY: min_disp_ff <= csr_ch.data[PIX_W-1:0];
            default: ;
         endcase
      end
   end

   // Disparity check, baseline magnitude and principal-point offsets
   always_comb begin
      logic bneg;
      bneg = baseline_ff[COORD_W-1];
      s0_disp_in = req_ch.left_u - req_ch.right_u;
      s0_bmag_in = bneg ? (BMAG_W'(0) - baseline_ff) : baseline_ff;
      s0_side_in.rej = (req_ch.left_u <= req_ch.right_u) || (s0_disp_in < min_disp_ff);
      s0_side_in.dneg = !bneg && (s0_bmag_in != '0);
      s0_side_in.offx_neg = req_ch.left_u < prin_u_ff;
      s0_side_in.offx_mag = s0_side_in.offx_neg ? (prin_u_ff - req_ch.left_u)
                                                : (req_ch.left_u - prin_u_ff);
      s0_side_in.offy_neg = req_ch.left_v < prin_v_ff;
      s0_side_in.offy_mag = s0_side_in.offy_neg ? (prin_v_ff - req_ch.left_v)
                                                : (req_ch.left_v - prin_v_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (adv) begin
         s0_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s0_side_ff <= s0_side_in;
         s0_bmag_ff <= s0_bmag_in;
         s0_disp_ff <= s0_disp_in;
      end
   end

   // Depth quotient: |baseline| * 2^20 / disparity
   sptri_divider #(
      .NUM_W (Q_W),
      .DEN_W (PIX_W),
      .SIDE_W(SIDE1_W)
   ) u_div_depth (
      .clock    (clock),
      .reset    (reset),
      .enable   (adv),
      .in_valid (s0_valid_ff),
      .in_num   ({s0_bmag_ff, Q_SHIFT'(0)}),
      .in_den   (s0_disp_ff),
      .in_side  (s0_side_ff),
      .out_valid(d1_valid),
      .out_quot (d1_quot),
      .out_side (d1_side)
   );

   // Treat a zero focal length as one
   assign focal_eff  = (focal_ff == '0) ? PIX_W'(1) : focal_ff;
   assign d2_side_in = {d1_side, d1_quot[Q_W-1:Z_DROP]};

   // Depth per pixel: quotient * 16 / focal length
   sptri_divider #(
      .NUM_W (P_W),
      .DEN_W (PIX_W),
      .SIDE_W(SIDE2_W)
   ) u_div_focal (
      .clock    (clock),
      .reset    (reset),
      .enable   (adv),
      .in_valid (d1_valid),
      .in_num   ({d1_quot, P_SHIFT'(0)}),
      .in_den   (focal_eff),
      .in_side  (d2_side_in),
      .out_valid(d2_valid),
      .out_quot (d2_quot),
      .out_side (d2_side)
   );

   assign d2_side_s = d2_side;

   // Split the 56-bit factor into high and low partial products
   always_comb begin
      m1_phx_in = d2_quot[P_W-1:P_LO_W] * d2_side_s.s1.offx_mag;
      m1_phy_in = d2_quot[P_W-1:P_LO_W] * d2_side_s.s1.offy_mag;
      m1_plx_in = d2_quot[P_LO_W-1:0] * d2_side_s.s1.offx_mag;
      m1_ply_in = d2_quot[P_LO_W-1:0] * d2_side_s.s1.offy_mag;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_valid_ff <= 1'b0;
      end else if (adv) begin
         m1_valid_ff <= d2_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         m1_side_ff <= d2_side_s;
         m1_phx_ff  <= m1_phx_in;
         m1_phy_ff  <= m1_phy_in;
         m1_plx_ff  <= m1_plx_in;
         m1_ply_ff  <= m1_ply_in;
      end
   end

   // Recombine partial products, drop 20 fraction bits, clamp to Q16.16; zero a rejected pair
   always_comb begin
      xm = {m1_phx_ff, HI_SHIFT'(0)} + MAG_W'(m1_plx_ff[PLO_PROD_W-1:XY_SHIFT]);
      ym = {m1_phy_ff, HI_SHIFT'(0)} + MAG_W'(m1_ply_ff[PLO_PROD_W-1:XY_SHIFT]);
      cx = clamp_q16(xm, m1_side_ff.s1.dneg ^ m1_side_ff.s1.offx_neg);
      cy = clamp_q16(ym, m1_side_ff.s1.dneg ^ m1_side_ff.s1.offy_neg);
      cz = clamp_q16(MAG_W'(m1_side_ff.zmag), m1_side_ff.s1.dneg);
      if (m1_side_ff.s1.rej) begin
         m2_res_in = 1'b0;
         m2_sat_in = 1'b0;
         m2_x_in   = '0;
         m2_y_in   = '0;
         m2_z_in   = '0;
      end else begin
         m2_res_in = 1'b1;
         m2_sat_in = cx.sat | cy.sat | cz.sat;
         m2_x_in   = cx.value;
         m2_y_in   = cy.value;
         m2_z_in   = cz.value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m2_valid_ff <= 1'b0;
      end else if (adv) begin
         m2_valid_ff <= m1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         m2_res_ff <= m2_res_in;
         m2_sat_ff <= m2_sat_in;
         m2_x_ff   <= m2_x_in;
         m2_y_ff   <= m2_y_in;
         m2_z_ff   <= m2_z_in;
      end
   end

   // Output register: load from the last stage, drop on a completed transfer
   always_comb begin
      if (adv && m2_valid_ff) begin
         out_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && m2_valid_ff) begin
         out_res_ff <= m2_res_ff;
         out_sat_ff <= m2_sat_ff;
         out_x_ff   <= m2_x_ff;
         out_y_ff   <= m2_y_ff;
         out_z_ff   <= m2_z_ff;
      end
   end

   assign rsp_ch.valid     = out_valid_ff;
   assign rsp_ch.valid_res = out_res_ff;
   assign rsp_ch.saturated = out_sat_ff;
   assign rsp_ch.cam_x     = out_x_ff;
   assign rsp_ch.cam_y     = out_y_ff;
   assign rsp_ch.cam_z     = out_z_ff;
endmodule

// ===== rtl/sptri_div_cell.sv =====
// One restoring-division cell: resolves a single quotient bit and hands on.
module sptri_div_cell #(
   parameter int NUM_W  = 52,
   parameter int DEN_W  = 16,
   parameter int SIDE_W = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              enable,
   input  logic              in_valid,
   input  logic [DEN_W-1:0]  in_rem,
   input  logic [NUM_W-1:0]  in_work,
   input  logic [DEN_W-1:0]  in_den,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [DEN_W-1:0]  out_rem,
   output logic [NUM_W-1:0]  out_work,
   output logic [DEN_W-1:0]  out_den,
   output logic [SIDE_W-1:0] out_side
);
   logic              valid_ff;
   logic [DEN_W-1:0]  rem_ff, rem_in;
   logic [NUM_W-1:0]  work_ff, work_in;
   logic [DEN_W-1:0]  den_ff;
   logic [SIDE_W-1:0] side_ff;
   logic [DEN_W:0]    trial, diff;
   logic              q_bit;

   // Shift the next dividend bit into the remainder, subtract where it fits
   always_comb begin
      trial   = {in_rem, in_work[NUM_W-1]};
      diff    = trial - {1'b0, in_den};
      q_bit   = trial >= {1'b0, in_den};
      rem_in  = q_bit ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      work_in = {in_work[NUM_W-2:0], q_bit};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff  <= rem_in;
         work_ff <= work_in;
         den_ff  <= in_den;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_rem   = rem_ff;
   assign out_work  = work_ff;
   assign out_den   = den_ff;
   assign out_side  = side_ff;
endmodule

// ===== rtl/sptri_divider.sv =====
// Pipelined divider: a chain of NUM_W cells, one quotient bit per cell.
module sptri_divider #(
   parameter int NUM_W  = 52,
   parameter int DEN_W  = 16,
   parameter int SIDE_W = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              enable,
   input  logic              in_valid,
   input  logic [NUM_W-1:0]  in_num,
   input  logic [DEN_W-1:0]  in_den,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [NUM_W-1:0]  out_quot,
   output logic [SIDE_W-1:0] out_side
);
   logic              valid_s [NUM_W+1];
   logic [DEN_W-1:0]  rem_s   [NUM_W+1];
   logic [NUM_W-1:0]  work_s  [NUM_W+1];
   logic [DEN_W-1:0]  den_s   [NUM_W+1];
   logic [SIDE_W-1:0] side_s  [NUM_W+1];

   assign valid_s[0] = in_valid;
   assign rem_s[0]   = '0;
   assign work_s[0]  = in_num;
   assign den_s[0]   = in_den;
   assign side_s[0]  = in_side;

   for (genvar i = 0; i < NUM_W; i++) begin : g_cell
      sptri_div_cell #(
         .NUM_W (NUM_W),
         .DEN_W (DEN_W),
         .SIDE_W(SIDE_W)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .enable   (enable),
         .in_valid (valid_s[i]),
         .in_rem   (rem_s[i]),
         .in_work  (work_s[i]),
         .in_den   (den_s[i]),
         .in_side  (side_s[i]),
         .out_valid(valid_s[i+1]),
         .out_rem  (rem_s[i+1]),
         .out_work (work_s[i+1]),
         .out_den  (den_s[i+1]),
         .out_side (side_s[i+1])
      );
   end

   assign out_valid = valid_s[NUM_W];
   assign out_quot  = work_s[NUM_W];
   assign out_side  = side_s[NUM_W];
endmodule

// ===== rtl/sptri_checker.sv =====
// Port-level checks for the stereo triangulator, bound to the top level.
module sptri_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_ready,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic                               valid_res,
   input logic                               saturated,
   input logic signed [sptri_pkg::COORD_W-1:0] cam_x,
   input logic signed [sptri_pkg::COORD_W-1:0] cam_y,
   input logic signed [sptri_pkg::COORD_W-1:0] cam_z
);
   import sptri_pkg::*;

   // A stalled result stays valid and keeps its x and z values
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(cam_z) && $stable(cam_x))
      else $error("result changed while stalled");

   // A rejected pair reports all zeros
   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !valid_res |-> !saturated && cam_x == '0 && cam_y == '0 && cam_z == '0)
      else $error("rejected pair carries non-zero result");

   // Saturation only on an accepted pair
   a_sat_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && saturated |-> valid_res)
      else $error("saturation flagged on rejected pair");

   // Input is held off only while the output is blocked
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input stalled without output back-pressure");
endmodule

bind stereo_point_triangulator_unit sptri_checker u_sptri_checker (
   .clock    (clock),
   .reset    (reset),
   .req_ready(req_ch.ready),
   .rsp_valid(rsp_ch.valid),
   .rsp_ready(rsp_ch.ready),
   .valid_res(rsp_ch.valid_res),
   .saturated(rsp_ch.saturated),
   .cam_x    (rsp_ch.cam_x),
   .cam_y    (rsp_ch.cam_y),
   .cam_z    (rsp_ch.cam_z)
);

// ===== tb/sv/tb_stereo_point_triangulator_unit.sv =====
// Self-checking testbench for the stereo point triangulator: random and directed pairs.
`timescale 1ns / 1ps

module tb_stereo_point_triangulator_unit;
   import sptri_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int CHOKE_CYCLES = 300;
   localparam int DRAIN_CYCLES = 130;

   localparam logic [CSR_ADDR_W-1:0] CSR_SPARE_LO = 3'd5;
   localparam logic [CSR_ADDR_W-1:0] CSR_SPARE_HI = 3'd7;

   typedef struct packed {
      logic [PIX_W-1:0] left_u;
      logic [PIX_W-1:0] left_v;
      logic [PIX_W-1:0] right_u;
   } stereo_pair_type;

   typedef struct packed {
      logic               valid_res;
      logic               saturated;
      logic [COORD_W-1:0] cam_x;
      logic [COORD_W-1:0] cam_y;
      logic [COORD_W-1:0] cam_z;
   } cam_point_type;

   logic clock;
   logic reset;

   sptri_req_if req_bus();
   sptri_rsp_if rsp_bus();
   sptri_csr_if csr_bus();

   stereo_point_triangulator_unit DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus),
      .csr_ch (csr_bus)
   );

   // Camera setting as the block should hold it
   logic [PIX_W-1:0]   cfg_focal;
   logic [PIX_W-1:0]   cfg_pu;
   logic [PIX_W-1:0]   cfg_pv;
   logic [COORD_W-1:0] cfg_base;
   logic [PIX_W-1:0]   cfg_min;

   stereo_pair_type pair_queue[$];
   cam_point_type   expected_points[$];
   stereo_pair_type pair_on_bus;

   bit idle_on;
   bit choke_request;
   bit choke_taken;
   int choke_left;
   int send_gap;
   int take_gap;

   int cycle_count;
   int mismatches;
   int points_seen;
   int points_valid;
   int points_clamped;
   int settings_used;

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // trunc(p * b / 2^20) split so that no product overflows 64 bits
   function automatic logic [63:0] scale_offset(input logic [63:0] p, input logic [63:0] b);
      logic [63:0] hi;
      logic [63:0] lo;
      hi = p >> 32;
      lo = p & 64'h0000_0000_FFFF_FFFF;
      return ((hi * b) << 12) + ((lo * b) >> 20);
   endfunction

   function automatic logic [COORD_W-1:0] saturate_q16(input logic [63:0] mag, input logic neg,
                                                       output logic clipped);
      logic [63:0] lim;
      logic [63:0] m;
      lim = neg ? 64'h0000_0000_8000_0000 : 64'h0000_0000_7FFF_FFFF;
      clipped = mag > lim;
      m = clipped ? lim : mag;
      return neg ? COORD_W'(64'd0 - m) : m[COORD_W-1:0];
   endfunction

   function automatic cam_point_type triangulate(input stereo_pair_type pr);
      cam_point_type r;
      logic [63:0]   disp;
      logic [63:0]   bmag;
      logic [63:0]   quot;
      logic [63:0]   foc;
      logic [63:0]   dpp;
      logic [63:0]   offm;
      logic          bneg;
      logic          zneg;
      logic          oneg;
      logic          sx;
      logic          sy;
      logic          sz;
      r = '0;
      if (pr.left_u <= pr.right_u) begin
         return r;
      end
      disp = 64'(pr.left_u) - 64'(pr.right_u);
      if (disp < 64'(cfg_min)) begin
         return r;
      end
      bneg = cfg_base[COORD_W-1];
      bmag = bneg ? (64'h1_0000_0000 - 64'(cfg_base)) : 64'(cfg_base);
      // depth takes the opposite sign of the baseline term
      zneg = !bneg && (bmag != 0);
      quot = (bmag << 20) / disp;
      foc  = (cfg_focal == 0) ? 64'd1 : 64'(cfg_focal);
      dpp  = (quot << 4) / foc;

      oneg = pr.left_u < cfg_pu;
      offm = oneg ? 64'(cfg_pu) - 64'(pr.left_u) : 64'(pr.left_u) - 64'(cfg_pu);
      r.cam_x = saturate_q16(scale_offset(dpp, offm), zneg != oneg, sx);

      oneg = pr.left_v < cfg_pv;
      offm = oneg ? 64'(cfg_pv) - 64'(pr.left_v) : 64'(pr.left_v) - 64'(cfg_pv);
      r.cam_y = saturate_q16(scale_offset(dpp, offm), zneg != oneg, sy);

      r.cam_z = saturate_q16(quot >> 16, zneg, sz);
      r.valid_res = 1'b1;
      r.saturated = sx | sy | sz;
      return r;
   endfunction

   // Mostly well-formed pairs that pass the disparity gate, the rest raw noise
   function automatic stereo_pair_type random_pair(input bit well_formed);
      stereo_pair_type p;
      int unsigned     lo_d;
      int unsigned     d;
      p.left_v = 16'($urandom);
      if (!well_formed) begin
         p.left_u  = 16'($urandom);
         p.right_u = 16'($urandom);
         return p;
      end
      lo_d = (cfg_min == 0) ? 1 : cfg_min;
      p.left_u = 16'($urandom_range(65535, lo_d));
      if ($urandom_range(0, 3) == 0) begin
         d = lo_d + $urandom_range(0, 15);
         if (d > p.left_u) begin
            d = p.left_u;
         end
      end else begin
         d = $urandom_range(p.left_u, lo_d);
      end
      p.right_u = p.left_u - 16'(d);
      return p;
   endfunction

   task automatic queue_pair(input int lu, input int lv, input int ru);
      stereo_pair_type p;
      p.left_u  = 16'(lu);
      p.left_v  = 16'(lv);
      p.right_u = 16'(ru);
      pair_queue.push_back(p);
   endtask

   task automatic write_reg(input logic [CSR_ADDR_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.addr  <= idx;
      csr_bus.data  <= val;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      case (idx)
         CSR_FOCAL_LENGTH:  cfg_focal = val[PIX_W-1:0];
         CSR_PRINCIPAL_U:   cfg_pu    = val[PIX_W-1:0];
         CSR_PRINCIPAL_V:   cfg_pv    = val[PIX_W-1:0];
         CSR_BASELINE_TERM: cfg_base  = val;
         CSR_MIN_DISPARITY: cfg_min   = val[PIX_W-1:0];
         default: ;
      endcase
   endtask

   task automatic program_setting(input logic [31:0] focal, input logic [31:0] pu,
                                  input logic [31:0] pv, input logic [31:0] base,
                                  input logic [31:0] mind);
      write_reg(CSR_FOCAL_LENGTH, focal);
      write_reg(CSR_PRINCIPAL_U, pu);
      write_reg(CSR_PRINCIPAL_V, pv);
      write_reg(CSR_BASELINE_TERM, base);
      write_reg(CSR_MIN_DISPARITY, mind);
      settings_used++;
   endtask

   // Hold until every pair is taken and every point has come back
   task automatic wait_drained();
      do @(negedge clock);
      while (pair_queue.size() != 0 || req_bus.valid || expected_points.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic check_point();
      cam_point_type want;
      cam_point_type got;
      got.valid_res = rsp_bus.valid_res;
      got.saturated = rsp_bus.saturated;
      got.cam_x     = rsp_bus.cam_x;
      got.cam_y     = rsp_bus.cam_y;
      got.cam_z     = rsp_bus.cam_z;
      points_seen++;
      if (got.valid_res) points_valid++;
      if (got.saturated) points_clamped++;
      if (expected_points.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("point with nothing outstanding: valid_res=%0b sat=%0b x=%h y=%h z=%h",
                     got.valid_res, got.saturated, got.cam_x, got.cam_y, got.cam_z);
         end
         return;
      end
      want = expected_points.pop_front();
      if (want !== got) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("point %0d mismatch: valid_res %0b/%0b sat %0b/%0b", points_seen,
                     want.valid_res, got.valid_res, want.saturated, got.saturated);
            $display("   x %h/%h  y %h/%h  z %h/%h (expected/actual)",
                     want.cam_x, got.cam_x, want.cam_y, got.cam_y, want.cam_z, got.cam_z);
         end
      end
   endtask

   // Pair driver
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         send_gap      <= 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            expected_points.push_back(triangulate(pair_on_bus));
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (send_gap != 0) begin
               send_gap      <= send_gap - 1;
               req_bus.valid <= 1'b0;
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
               send_gap      <= $urandom_range(0, 4);
               req_bus.valid <= 1'b0;
            end else if (pair_queue.size() != 0) begin
               pair_on_bus = pair_queue.pop_front();
               req_bus.left_u  <= pair_on_bus.left_u;
               req_bus.left_v  <= pair_on_bus.left_v;
               req_bus.right_u <= pair_on_bus.right_u;
               req_bus.valid   <= 1'b1;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // Long receiver hold-off, armed once
   always @(posedge clock) begin
      if (reset) begin
         choke_left  <= 0;
         choke_taken <= 1'b0;
      end else if (choke_request && !choke_taken) begin
         choke_left  <= CHOKE_CYCLES;
         choke_taken <= 1'b1;
      end else if (choke_left != 0) begin
         choke_left <= choke_left - 1;
      end
   end

   // Point monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         take_gap      <= 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            check_point();
         end
         if (choke_left != 0) begin
            rsp_bus.ready <= 1'b0;
         end else if (take_gap != 0) begin
            take_gap      <= take_gap - 1;
            rsp_bus.ready <= 1'b0;
         end else if (idle_on && $urandom_range(0, 3) == 0) begin
            take_gap      <= $urandom_range(0, 4);
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timed out after %0d cycles with %0d points outstanding",
                  cycle_count, expected_points.size());
         $display("tb_stereo_point_triangulator_unit: errors");
         $finish;
      end
   end

   initial begin
      logic [31:0] focal;
      logic [31:0] base;
      logic [31:0] mind;
      int          count;

      reset           = 1'b1;
      req_bus.valid   = 1'b0;
      req_bus.left_u  = '0;
      req_bus.left_v  = '0;
      req_bus.right_u = '0;
      rsp_bus.ready   = 1'b0;
      csr_bus.valid   = 1'b0;
      csr_bus.addr    = '0;
      csr_bus.data    = '0;
      cfg_focal       = FOCAL_RESET;
      cfg_pu          = PRIN_U_RESET;
      cfg_pv          = PRIN_V_RESET;
      cfg_base        = BASELINE_RESET;
      cfg_min         = MIN_DISP_RESET;
      idle_on         = 1'b1;
      choke_request   = 1'b0;
      cycle_count     = 0;
      mismatches      = 0;
      points_seen     = 0;
      points_valid    = 0;
      points_clamped  = 0;
      settings_used   = 1;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Reset setting: disparity gate edges, zero and negative disparity, field extremes
      @(negedge clock);
      queue_pair(5120, 3840, 5104);
      queue_pair(5120, 3840, 5105);
      queue_pair(5120, 3840, 5120);
      queue_pair(5000, 3000, 6000);
      queue_pair(65535, 65535, 0);
      queue_pair(65535, 0, 0);
      queue_pair(0, 0, 0);
      queue_pair(16, 65535, 0);
      queue_pair(65535, 0, 65519);
      queue_pair(40000, 20000, 39000);
      queue_pair(8000, 100, 7000);
      wait_drained();

      // Zero focal length, most negative baseline, no gate: every accepted pair clamps
      program_setting(0, 0, 65535, 32'h8000_0000, 0);
      write_reg(CSR_SPARE_LO, 32'hFFFF_FFFF);
      write_reg(CSR_SPARE_HI, 32'h0000_0001);
      @(negedge clock);
      queue_pair(1, 0, 0);
      queue_pair(65535, 0, 65534);
      queue_pair(65535, 65535, 0);
      queue_pair(100, 100, 100);
      queue_pair(5, 7, 9);
      queue_pair(0, 0, 0);
      wait_drained();

      // Positive baseline gives negative depth; widest gate leaves two accepted pairs
      program_setting(65535, 65535, 0, 32'h7FFF_FFFF, 65535);
      @(negedge clock);
      queue_pair(65535, 65535, 0);
      queue_pair(65535, 0, 0);
      queue_pair(65535, 32768, 1);
      queue_pair(0, 0, 0);
      wait_drained();

      for (int ph = 0; ph < 6; ph++) begin
         case ($urandom_range(0, 7))
            0:       focal = 1;
            1:       focal = 65535;
            default: focal = $urandom_range(800, 20000);
         endcase
         case ($urandom_range(0, 7))
            0:       base = 32'h0;
            1:       base = 32'h8000_0000;
            2:       base = 32'h7FFF_FFFF;
            3:       base = $urandom;
            default: base = 32'd0 - $urandom_range(1, 32'h0400_0000);
         endcase
         mind = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 512);
         program_setting(focal, $urandom_range(0, 65535), $urandom_range(0, 65535), base, mind);

         @(negedge clock);
         idle_on = (ph != 1) && (ph != 3) && (ph != 5);
         count = 100;
         if (ph == 1) begin
            // stall the receiver while pairs keep coming so the pipeline backs up
            choke_request = 1'b1;
            count = 200;
         end
         for (int i = 0; i < count; i++) begin
            pair_queue.push_back(random_pair($urandom_range(0, 4) != 0));
         end
         wait_drained();
      end

      repeat (DRAIN_CYCLES) @(negedge clock);
      $display("%0d points checked over %0d camera settings: %0d accepted, %0d rejected",
               points_seen, settings_used, points_valid, points_seen - points_valid);
      $display("%0d points clamped, receiver held off %0d cycles once, %0d mismatches",
               points_clamped, CHOKE_CYCLES, mismatches);
      if (mismatches == 0 && expected_points.size() == 0) begin
         $display("tb_stereo_point_triangulator_unit: clean");
      end else begin
         $display("tb_stereo_point_triangulator_unit: errors");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/sptri_pkg.sv
rtl/sptri_req_if.sv
rtl/sptri_rsp_if.sv
rtl/sptri_csr_if.sv
rtl/sptri_div_cell.sv
rtl/sptri_divider.sv
rtl/stereo_point_triangulator_unit.sv
rtl/sptri_checker.sv
tb/sv/tb_stereo_point_triangulator_unit.sv
